// ===== hw/rtl/cpsc_pkg.sv =====
// Shared types and constants for the cascaded position/speed controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cpsc_pkg;

   // Field and datapath widths
   localparam int GAIN_W     = 16;
   localparam int DB_W       = 10;
   localparam int CLIM_W     = 15;
   localparam int DLIM_W     = 7;
   localparam int IN_W       = 16;
   localparam int ERR_W      = 17;
   localparam int DIFF_W     = 18;
   localparam int INT_W      = 24;
   localparam int OPND_W     = 25;
   localparam int FRAC_W     = 8;
   localparam int PROD_W     = GAIN_W + 1 + OPND_W;
   localparam int QUOT_W     = PROD_W - FRAC_W;
   localparam int CMD_W      = 16;
   localparam int DRV_W      = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POS_GAIN        = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_GAIN   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIVATIVE_GAIN = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN      = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND        = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_WINDOW = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_LIMIT   = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT     = 8'd7;

   // Register reset values
   localparam logic [GAIN_W-1:0] RST_POS_GAIN        = 16'd384;
   localparam logic [GAIN_W-1:0] RST_INTEGRAL_GAIN   = 16'd38;
   localparam logic [GAIN_W-1:0] RST_DERIVATIVE_GAIN = 16'd0;
   localparam logic [GAIN_W-1:0] RST_SPEED_GAIN      = 16'd77;
   localparam logic [DB_W-1:0]   RST_DEADBAND        = 10'd5;
   localparam logic [DB_W-1:0]   RST_INTEGRAL_WINDOW = 10'd35;
   localparam logic [CLIM_W-1:0] RST_COMMAND_LIMIT   = 15'd400;
   localparam logic [DLIM_W-1:0] RST_DRIVE_LIMIT     = 7'd127;

   // Integral saturation bounds
   localparam logic signed [INT_W-1:0] INT_MAX = 24'sh7FFFFF;
   localparam logic signed [INT_W-1:0] INT_MIN = 24'sh800000;

   typedef struct packed {
      logic [GAIN_W-1:0] pos_gain;
      logic [GAIN_W-1:0] integral_gain;
      logic [GAIN_W-1:0] derivative_gain;
      logic [GAIN_W-1:0] speed_gain;
      logic [DB_W-1:0]   deadband;
      logic [DB_W-1:0]   integral_window;
      logic [CLIM_W-1:0] command_limit;
      logic [DLIM_W-1:0] drive_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_INT,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC_I,
      ST_ACC_D,
      ST_CMD,
      ST_SPD,
      ST_MUL_S,
      ST_WAIT_S,
      ST_DRV
   } state_type;

   // Operand select for the shared multiplier
   typedef enum logic [1:0] {
      OP_POS,
      OP_INT,
      OP_DER,
      OP_SPD
   } op_type;

   typedef struct packed {
      logic   err_ld;
      logic   int_ld;
      logic   acc_ld;
      logic   acc_add;
      logic   cmd_ld;
      logic   spd_ld;
      logic   drv_ld;
      op_type op_sel;
   } ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cascaded_position_speed_control_core.sv =====
// Cascaded position/speed controller: one result per input transaction.
// Items running the outer position PID pass through the error, integral,
// multiply, accumulate and command steps before the speed loop, which
// speed-loop-only items enter directly; one shared multiplier serves all four
// gain products in turn. A new transaction is taken only in idle; the last
// step holds while an earlier result waits on rsp_ready. Synchronous reset
// clears the sequencer, loop state and result valid; config takes reset values.
`default_nettype none

module cascaded_position_speed_control_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [cpsc_pkg::IN_W-1:0]            req_position,
   input  wire logic [cpsc_pkg::IN_W-1:0]            req_target,
   input  wire logic [cpsc_pkg::IN_W-1:0]            req_speed,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [cpsc_pkg::DRV_W-1:0]         rsp_drive,
   output logic signed [cpsc_pkg::CMD_W-1:0]         rsp_speed_command,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [cpsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [cpsc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import cpsc_pkg::*;

   cfg_type   cfg;
   ctl_type   ctl;
   state_type state_ff;
   state_type state_in;

   logic                     req_acc;
   logic [IN_W-1:0]          pos_ff;
   logic [IN_W-1:0]          tgt_ff;
   logic [IN_W-1:0]          spd_ff;
   logic                     outer_due_ff;

   logic signed [ERR_W-1:0]  err_raw;
   logic [ERR_W-1:0]         mag_raw;
   logic                     in_deadband;
   logic signed [ERR_W-1:0]  err_ff;
   logic [ERR_W-1:0]         mag_ff;
   logic signed [ERR_W-1:0]  prev_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [INT_W-1:0]  int_ff;
   logic signed [INT_W:0]    int_sum;
   logic signed [INT_W-1:0]  int_sat;
   logic signed [QUOT_W-1:0] acc_ff;
   logic signed [CMD_W-1:0]  held_ff;
   logic signed [DIFF_W-1:0] sdiff_ff;

   logic [GAIN_W-1:0]        mul_gain;
   logic signed [OPND_W-1:0] mul_opnd;
   logic signed [QUOT_W-1:0] quot;
   logic signed [QUOT_W-1:0] clim;
   logic signed [QUOT_W-1:0] dlim;
   logic signed [QUOT_W-1:0] cmd_sat;
   logic signed [QUOT_W-1:0] drv_sat;

   logic                     rsp_valid_ff;
   logic signed [DRV_W-1:0]  drive_ff;
   logic signed [CMD_W-1:0]  cmd_out_ff;

   cpsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cpsc_mul u_mul (
      .clock (clock),
      .gain  (mul_gain),
      .opnd  (mul_opnd),
      .quot  (quot)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_acc) state_in = outer_due_ff ? ST_ERR : ST_SPD;
         ST_ERR:    state_in = ST_INT;
         ST_INT:    state_in = ST_MUL_P;
         ST_MUL_P:  state_in = ST_MUL_I;
         ST_MUL_I:  state_in = ST_MUL_D;
         ST_MUL_D:  state_in = ST_ACC_I;
         ST_ACC_I:  state_in = ST_ACC_D;
         ST_ACC_D:  state_in = ST_CMD;
         ST_CMD:    state_in = ST_SPD;
         ST_SPD:    state_in = ST_MUL_S;
         ST_MUL_S:  state_in = ST_WAIT_S;
         ST_WAIT_S: state_in = ST_DRV;
         ST_DRV:    if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer control strobes
   always_comb begin
      ctl        = '0;
      ctl.op_sel = OP_SPD;
      case (state_ff)
         ST_ERR:   ctl.err_ld = 1'b1;
         ST_INT:   ctl.int_ld = 1'b1;
         ST_MUL_P: ctl.op_sel = OP_POS;
         ST_MUL_I: ctl.op_sel = OP_INT;
         ST_MUL_D: begin
            ctl.op_sel = OP_DER;
            ctl.acc_ld = 1'b1;
         end
         ST_ACC_I: ctl.acc_add = 1'b1;
         ST_ACC_D: ctl.acc_add = 1'b1;
         ST_CMD:   ctl.cmd_ld = 1'b1;
         ST_SPD:   ctl.spd_ld = 1'b1;
         ST_DRV:   ctl.drv_ld = !rsp_valid_ff || rsp_ready;
         default:  ctl.op_sel = OP_SPD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Input capture and outer-loop cadence
   always_ff @(posedge clock) begin
      if (reset) begin
         outer_due_ff <= 1'b1;
      end else if (req_acc) begin
         outer_due_ff <= !outer_due_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pos_ff <= req_position;
         tgt_ff <= req_target;
         spd_ff <= req_speed;
      end
   end

   // Position error with deadband
   assign err_raw     = $signed({1'b0, tgt_ff}) - $signed({1'b0, pos_ff});
   assign mag_raw     = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
   assign in_deadband = mag_raw < {{(ERR_W-DB_W){1'b0}}, cfg.deadband};

   // Integral update, saturating at 24 bits
   assign int_sum = {int_ff[INT_W-1], int_ff} + {{(INT_W+1-ERR_W){err_ff[ERR_W-1]}}, err_ff};
   always_comb begin
      if (int_sum[INT_W] != int_sum[INT_W-1]) begin
         int_sat = int_sum[INT_W] ? INT_MIN : INT_MAX;
      end else begin
         int_sat = int_sum[INT_W-1:0];
      end
   end

   // Shared multiplier operand select
   always_comb begin
      case (ctl.op_sel)
         OP_POS: begin
            mul_gain = cfg.pos_gain;
            mul_opnd = {{(OPND_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         OP_INT: begin
            mul_gain = cfg.integral_gain;
            mul_opnd = {{(OPND_W-INT_W){int_ff[INT_W-1]}}, int_ff};
         end
         OP_DER: begin
            mul_gain = cfg.derivative_gain;
            mul_opnd = {{(OPND_W-DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
         end
         default: begin
            mul_gain = cfg.speed_gain;
            mul_opnd = {{(OPND_W-DIFF_W){sdiff_ff[DIFF_W-1]}}, sdiff_ff};
         end
      endcase
   end

   // Symmetric saturation of command and drive
   assign clim = $signed({{(QUOT_W-CLIM_W){1'b0}}, cfg.command_limit});
   assign dlim = $signed({{(QUOT_W-DLIM_W){1'b0}}, cfg.drive_limit});

   always_comb begin
      if (acc_ff > clim) begin
         cmd_sat = clim;
      end else if (acc_ff < -clim) begin
         cmd_sat = -clim;
      end else begin
         cmd_sat = acc_ff;
      end
   end

   always_comb begin
      if (quot > dlim) begin
         drv_sat = dlim;
      end else if (quot < -dlim) begin
         drv_sat = -dlim;
      end else begin
         drv_sat = quot;
      end
   end

   // Outer loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         int_ff  <= '0;
         held_ff <= '0;
      end else begin
         if (ctl.int_ld) begin
            prev_ff <= err_ff;
            if (mag_ff < {{(ERR_W-DB_W){1'b0}}, cfg.integral_window}) begin
               int_ff <= int_sat;
            end
         end
         if (ctl.cmd_ld) begin
            held_ff <= cmd_sat[CMD_W-1:0];
            if (err_ff == '0) begin
               int_ff <= '0;
            end
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (ctl.err_ld) begin
         err_ff <= in_deadband ? '0 : err_raw;
         mag_ff <= in_deadband ? '0 : mag_raw;
      end
      if (ctl.int_ld) begin
         diff_ff <= {err_ff[ERR_W-1], err_ff} - {prev_ff[ERR_W-1], prev_ff};
      end
      if (ctl.acc_ld) begin
         acc_ff <= quot;
      end else if (ctl.acc_add) begin
         acc_ff <= acc_ff + quot;
      end
      if (ctl.spd_ld) begin
         sdiff_ff <= {{(DIFF_W-CMD_W){held_ff[CMD_W-1]}}, held_ff} - $signed({2'b0, spd_ff});
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.drv_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.drv_ld) begin
         drive_ff   <= drv_sat[DRV_W-1:0];
         cmd_out_ff <= held_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive         = drive_ff;
   assign rsp_speed_command = cmd_out_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cpsc_csr.sv =====
// Configuration register file for the controller.
// Depends on cpsc_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module cpsc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cpsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cpsc_pkg::CSR_DATA_W-1:0]    csr_data,
   output cpsc_pkg::cfg_type                       cfg
);
   import cpsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes must arrive only while the block is idle; the block does not enforce it
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode one write; unknown indexes leave everything unchanged
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POS_GAIN:        cfg_in.pos_gain        = csr_data[GAIN_W-1:0];
            CSR_INTEGRAL_GAIN:   cfg_in.integral_gain   = csr_data[GAIN_W-1:0];
            CSR_DERIVATIVE_GAIN: cfg_in.derivative_gain = csr_data[GAIN_W-1:0];
            CSR_SPEED_GAIN:      cfg_in.speed_gain      = csr_data[GAIN_W-1:0];
            CSR_DEADBAND:        cfg_in.deadband        = csr_data[DB_W-1:0];
            CSR_INTEGRAL_WINDOW: cfg_in.integral_window = csr_data[DB_W-1:0];
            CSR_COMMAND_LIMIT:   cfg_in.command_limit   = csr_data[CLIM_W-1:0];
            CSR_DRIVE_LIMIT:     cfg_in.drive_limit     = csr_data[DLIM_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_gain        <= RST_POS_GAIN;
         cfg_ff.integral_gain   <= RST_INTEGRAL_GAIN;
         cfg_ff.derivative_gain <= RST_DERIVATIVE_GAIN;
         cfg_ff.speed_gain      <= RST_SPEED_GAIN;
         cfg_ff.deadband        <= RST_DEADBAND;
         cfg_ff.integral_window <= RST_INTEGRAL_WINDOW;
         cfg_ff.command_limit   <= RST_COMMAND_LIMIT;
         cfg_ff.drive_limit     <= RST_DRIVE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cpsc_mul.sv =====
// Shared Q8.8 gain multiplier: unsigned gain times signed operand, then
// divide by 256 truncating toward zero. Two register stages. Uses cpsc_pkg.
`default_nettype none

module cpsc_mul (
   input  wire logic                                clock,
   input  wire logic [cpsc_pkg::GAIN_W-1:0]         gain,
   input  wire logic signed [cpsc_pkg::OPND_W-1:0]  opnd,
   output logic signed [cpsc_pkg::QUOT_W-1:0]       quot
);
   import cpsc_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] adj;
   logic signed [QUOT_W-1:0] quot_ff;
   logic signed [QUOT_W-1:0] quot_in;

   // Stage 1: product
   assign prod_in = $signed({1'b0, gain}) * opnd;

   // Stage 2: bias negatives by 255 so the shift rounds toward zero
   assign adj     = prod_ff + $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{prod_ff[PROD_W-1]}}});
   assign quot_in = adj[PROD_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cpsc_checker.sv =====
// Port-level checks for the controller core, bound to the top level.
// Depends on cpsc_pkg for port widths.
`default_nettype none

module cpsc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [cpsc_pkg::DRV_W-1:0]   rsp_drive,
   input wire logic signed [cpsc_pkg::CMD_W-1:0]   rsp_speed_command
);
   import cpsc_pkg::*;

   // Drive saturation is symmetric, so the most negative code never shows
   a_drive_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive != -8'sd128))
      else $error("drive outside symmetric range");

   // Command saturation is symmetric as well
   a_cmd_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed_command != -16'sd32768))
      else $error("speed command outside symmetric range");

   // One transaction at a time: busy right after an input is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while busy");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_drive)
                                     && $stable(rsp_speed_command)))
      else $error("result dropped or changed while stalled");

endmodule

bind cascaded_position_speed_control_core cpsc_checker u_cpsc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_drive         (rsp_drive),
   .rsp_speed_command (rsp_speed_command)
);

`default_nettype wire
